// File: rtl/utrb_pkg.sv
// utrb_pkg: shared types, constants and helpers for the uart ring buffer pair
// used by utrb_ctrl and uart_tx_rx_ring_buffers_unit; no dependencies
`default_nettype none

package utrb_pkg;

    // ring sizes
    localparam int unsigned TX_DEPTH = 32;
    localparam int unsigned RX_DEPTH = 256;

    // data width, and widths derived from the ring sizes
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned TX_PTR_W = $clog2(TX_DEPTH);
    localparam int unsigned RX_PTR_W = $clog2(RX_DEPTH);
    localparam int unsigned TX_CNT_W = $clog2(TX_DEPTH + 1);
    localparam int unsigned RX_CNT_W = $clog2(RX_DEPTH);

    // widths of the reported fill levels
    localparam int unsigned RX_COUNT_OUT_W = 8;
    localparam int unsigned TX_COUNT_OUT_W = 6;

    // receive fill level at which a request code is looked for
    localparam int unsigned REQ_COUNT = 5;

    // request codes
    localparam logic [DATA_W-1:0] REQ_CODE_A = 8'h80;
    localparam logic [DATA_W-1:0] REQ_CODE_B = 8'h82;
    localparam logic [DATA_W-1:0] REQ_CODE_C = 8'h90;
    localparam logic [DATA_W-1:0] REQ_CODE_D = 8'h92;
    localparam logic [DATA_W-1:0] REQ_CODE_E = 8'h32;

    typedef enum logic [1:0] {
        CMD_RX_BYTE    = 2'd0,
        CMD_TX_READY   = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_HOST_READ  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // one result word plus its strobe
    typedef struct packed {
        logic                      done;
        logic                      accepted;
        logic [DATA_W-1:0]         read_byte;
        logic                      read_valid;
        logic [DATA_W-1:0]         line_byte;
        logic                      line_valid;
        logic                      rx_overflow;
        logic                      echo_lost;
        logic                      request_detected;
        logic [RX_COUNT_OUT_W-1:0] rx_count;
        logic [TX_COUNT_OUT_W-1:0] tx_count;
    } t_result;

    // request to the transmit ring memory
    typedef struct packed {
        logic                we;
        logic [TX_PTR_W-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [TX_PTR_W-1:0] raddr;
    } t_tx_mem_req;

    // request to the receive ring memory
    typedef struct packed {
        logic                we;
        logic [RX_PTR_W-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [RX_PTR_W-1:0] raddr;
    } t_rx_mem_req;

    function automatic logic is_request_code(input logic [DATA_W-1:0] b);
        return (b == REQ_CODE_A) || (b == REQ_CODE_B) || (b == REQ_CODE_C) ||
               (b == REQ_CODE_D) || (b == REQ_CODE_E);
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_next_pos(input logic [TX_PTR_W-1:0] pos);
        return (pos == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic logic [RX_PTR_W-1:0] rx_next_pos(input logic [RX_PTR_W-1:0] pos);
        return (pos == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/utrb_ram.sv
// utrb_ram: generic single-port-write, single-port-read synchronous ram
// read data registered; no dependencies
`default_nettype none

module utrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/utrb_ctrl.sv
// utrb_ctrl: command sequencer, ring pointers and fill counters
// drives both ring memories; depends on utrb_pkg
`default_nettype none

module utrb_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_command,
    input  wire logic [utrb_pkg::DATA_W-1:0]   i_data_byte,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    output utrb_pkg::t_tx_mem_req              o_tx_req,
    input  wire logic [utrb_pkg::DATA_W-1:0]   i_tx_rdata,
    output utrb_pkg::t_rx_mem_req              o_rx_req,
    input  wire logic [utrb_pkg::DATA_W-1:0]   i_rx_rdata,
    output utrb_pkg::t_result                  o_res
);

    utrb_pkg::t_state r_state, n_state;
    utrb_pkg::t_cmd   r_cmd;
    logic [utrb_pkg::DATA_W-1:0] r_data;
    logic r_echo_enable;

    logic [utrb_pkg::TX_PTR_W-1:0] r_tx_rd_pos, n_tx_rd_pos;
    logic [utrb_pkg::TX_PTR_W-1:0] r_tx_wr_pos, n_tx_wr_pos;
    logic [utrb_pkg::TX_CNT_W-1:0] r_tx_fill, n_tx_fill;
    logic [utrb_pkg::RX_PTR_W-1:0] r_rx_rd_pos, n_rx_rd_pos;
    logic [utrb_pkg::RX_PTR_W-1:0] r_rx_wr_pos, n_rx_wr_pos;
    logic [utrb_pkg::RX_CNT_W-1:0] r_rx_fill, n_rx_fill;

    utrb_pkg::t_result r_res, n_res;

    logic w_accept;
    logic w_exec;
    logic w_tx_full, w_tx_empty, w_rx_full, w_rx_empty;

    assign w_accept = start && (r_state == utrb_pkg::ST_IDLE);
    assign w_exec   = (r_state == utrb_pkg::ST_EXEC);
    assign busy     = w_exec;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state: idle to execute on start, then back to idle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            utrb_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = utrb_pkg::ST_EXEC;
                end
            end
            utrb_pkg::ST_EXEC: begin
                n_state = utrb_pkg::ST_IDLE;
            end
        endcase
    end

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= utrb_pkg::t_cmd'(i_command);
            r_data <= i_data_byte;
        end
    end

    // echo enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_echo_enable <= i_cfg_data;
        end
    end

    // ring status
    assign w_tx_full  = (r_tx_fill == utrb_pkg::TX_CNT_W'(utrb_pkg::TX_DEPTH));
    assign w_tx_empty = (r_tx_fill == '0);
    assign w_rx_full  = (r_rx_fill == utrb_pkg::RX_CNT_W'(utrb_pkg::RX_DEPTH - 1));
    assign w_rx_empty = (r_rx_fill == '0);

    // execute: pointer and fill update, memory writes, result word
    always_comb begin
        n_tx_rd_pos = r_tx_rd_pos;
        n_tx_wr_pos = r_tx_wr_pos;
        n_tx_fill   = r_tx_fill;
        n_rx_rd_pos = r_rx_rd_pos;
        n_rx_wr_pos = r_rx_wr_pos;
        n_rx_fill   = r_rx_fill;

        // heads of both rings are read at the accept edge
        o_tx_req.re    = w_accept;
        o_tx_req.raddr = r_tx_rd_pos;
        o_rx_req.re    = w_accept;
        o_rx_req.raddr = r_rx_rd_pos;

        o_tx_req.we    = 1'b0;
        o_tx_req.waddr = r_tx_wr_pos;
        o_tx_req.wdata = r_data;
        o_rx_req.we    = 1'b0;
        o_rx_req.waddr = r_rx_wr_pos;
        o_rx_req.wdata = r_data;

        n_res      = '0;
        n_res.done = w_exec;

        if (w_exec) begin
            unique case (r_cmd)
                utrb_pkg::CMD_RX_BYTE: begin
                    if (!w_rx_full) begin
                        o_rx_req.we    = 1'b1;
                        n_rx_wr_pos    = utrb_pkg::rx_next_pos(r_rx_wr_pos);
                        n_rx_fill      = r_rx_fill + 1'b1;
                        n_res.accepted = 1'b1;
                    end else begin
                        n_res.rx_overflow = 1'b1;
                    end
                    n_res.request_detected =
                        (n_rx_fill == utrb_pkg::RX_CNT_W'(utrb_pkg::REQ_COUNT)) &&
                        utrb_pkg::is_request_code(r_data);
                end
                utrb_pkg::CMD_TX_READY: begin
                    if (!w_tx_empty) begin
                        n_tx_rd_pos      = utrb_pkg::tx_next_pos(r_tx_rd_pos);
                        n_tx_fill        = r_tx_fill - 1'b1;
                        n_res.line_byte  = i_tx_rdata;
                        n_res.line_valid = 1'b1;
                        n_res.accepted   = 1'b1;
                    end
                end
                utrb_pkg::CMD_HOST_WRITE: begin
                    if (!w_tx_full) begin
                        o_tx_req.we    = 1'b1;
                        n_tx_wr_pos    = utrb_pkg::tx_next_pos(r_tx_wr_pos);
                        n_tx_fill      = r_tx_fill + 1'b1;
                        n_res.accepted = 1'b1;
                    end
                end
                utrb_pkg::CMD_HOST_READ: begin
                    if (!w_rx_empty) begin
                        n_rx_rd_pos      = utrb_pkg::rx_next_pos(r_rx_rd_pos);
                        n_rx_fill        = r_rx_fill - 1'b1;
                        n_res.read_byte  = i_rx_rdata;
                        n_res.read_valid = 1'b1;
                        n_res.accepted   = 1'b1;
                        // echo the popped byte into the transmit ring
                        if (r_echo_enable) begin
                            if (!w_tx_full) begin
                                o_tx_req.we    = 1'b1;
                                o_tx_req.wdata = i_rx_rdata;
                                n_tx_wr_pos    = utrb_pkg::tx_next_pos(r_tx_wr_pos);
                                n_tx_fill      = r_tx_fill + 1'b1;
                            end else begin
                                n_res.echo_lost = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        n_res.rx_count = utrb_pkg::RX_COUNT_OUT_W'(n_rx_fill);
        n_res.tx_count = utrb_pkg::TX_COUNT_OUT_W'(n_tx_fill);
    end

    // pointers, fill counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rd_pos <= '0;
            r_tx_wr_pos <= '0;
            r_tx_fill   <= '0;
            r_rx_rd_pos <= '0;
            r_rx_wr_pos <= '0;
            r_rx_fill   <= '0;
            r_res       <= '0;
        end else begin
            r_tx_rd_pos <= n_tx_rd_pos;
            r_tx_wr_pos <= n_tx_wr_pos;
            r_tx_fill   <= n_tx_fill;
            r_rx_rd_pos <= n_rx_rd_pos;
            r_rx_wr_pos <= n_rx_wr_pos;
            r_rx_fill   <= n_rx_fill;
            r_res       <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: rtl/uart_tx_rx_ring_buffers_unit.sv
// uart_tx_rx_ring_buffers_unit: top level of the uart transmit/receive ring pair
// depends on utrb_pkg, utrb_ctrl and utrb_ram
//
// usage
//   command channel: a word (i_command, i_data_byte) is taken at a rising edge
//   with start high and busy low. commands: byte received, transmitter ready,
//   host write, host read.
//   result channel: o_done is high for exactly one cycle with the result word
//   on the o_ ports; the receiver cannot hold it off and must take it then.
//   configuration: i_cfg_we writes i_cfg_data into echo enable at a rising edge.
// sequence
//   the ring heads are read from memory at the accept edge; busy is high in
//   the execute state that follows, in which pointers, fill counts and ring
//   writes are updated and the result word is registered with its strobe.
//   no new word is taken while busy, so a word is finished before the next
//   one is taken.
// reset
//   synchronous, active low: pointers, fill counts, echo enable and the
//   strobe are cleared; ring contents are left as they are, no clearing pass.
`default_nettype none

module uart_tx_rx_ring_buffers_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    output logic            o_done,
    output logic            o_accepted,
    output logic [7:0]      o_read_byte,
    output logic            o_read_valid,
    output logic [7:0]      o_line_byte,
    output logic            o_line_valid,
    output logic            o_rx_overflow,
    output logic            o_echo_lost,
    output logic            o_request_detected,
    output logic [7:0]      o_rx_count,
    output logic [5:0]      o_tx_count
);

    utrb_pkg::t_tx_mem_req w_tx_req;
    utrb_pkg::t_rx_mem_req w_rx_req;
    logic [utrb_pkg::DATA_W-1:0] w_tx_rdata;
    logic [utrb_pkg::DATA_W-1:0] w_rx_rdata;
    utrb_pkg::t_result w_res;

    // sequencer
    utrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_tx_req    (w_tx_req),
        .i_tx_rdata  (w_tx_rdata),
        .o_rx_req    (w_rx_req),
        .i_rx_rdata  (w_rx_rdata),
        .o_res       (w_res)
    );

    // transmit ring storage
    utrb_ram #(
        .WIDTH (utrb_pkg::DATA_W),
        .DEPTH (utrb_pkg::TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (w_tx_req.we),
        .i_waddr (w_tx_req.waddr),
        .i_wdata (w_tx_req.wdata),
        .i_re    (w_tx_req.re),
        .i_raddr (w_tx_req.raddr),
        .o_rdata (w_tx_rdata)
    );

    // receive ring storage
    utrb_ram #(
        .WIDTH (utrb_pkg::DATA_W),
        .DEPTH (utrb_pkg::RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx_req.we),
        .i_waddr (w_rx_req.waddr),
        .i_wdata (w_rx_req.wdata),
        .i_re    (w_rx_req.re),
        .i_raddr (w_rx_req.raddr),
        .o_rdata (w_rx_rdata)
    );

    // unpack the result word
    assign o_done             = w_res.done;
    assign o_accepted         = w_res.accepted;
    assign o_read_byte        = w_res.read_byte;
    assign o_read_valid       = w_res.read_valid;
    assign o_line_byte        = w_res.line_byte;
    assign o_line_valid       = w_res.line_valid;
    assign o_rx_overflow      = w_res.rx_overflow;
    assign o_echo_lost        = w_res.echo_lost;
    assign o_request_detected = w_res.request_detected;
    assign o_rx_count         = w_res.rx_count;
    assign o_tx_count         = w_res.tx_count;

endmodule

`default_nettype wire

// File: rtl/utrb_checker.sv
// utrb_checker: port-level assertions for uart_tx_rx_ring_buffers_unit
// bound to the top level below; depends on nothing else
`default_nettype none

module utrb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic       o_accepted,
    input wire logic       o_read_valid,
    input wire logic       o_line_valid,
    input wire logic       o_rx_overflow,
    input wire logic       o_echo_lost
);

    // a taken word raises busy for the execute state, after which busy falls
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 !busy)
        else $error("busy did not cover exactly one cycle after accept");

    // every execute cycle is followed by a result strobe
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("execute cycle not followed by a result strobe");

    // a read or a line byte means the operation took effect
    a_valid_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_read_valid || o_line_valid)) |-> o_accepted)
        else $error("valid data reported without accepted");

    // a dropped byte is never reported as accepted
    a_overflow_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rx_overflow) |-> !o_accepted)
        else $error("overflow reported on an accepted word");

    // an echo loss only happens on a successful host read
    a_echo_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_echo_lost) |-> (o_read_valid && !o_line_valid))
        else $error("echo loss reported outside a host read");

endmodule

bind uart_tx_rx_ring_buffers_unit utrb_checker u_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for uart_tx_rx_ring_buffers_unit, the uart ring buffer pair
// depends on utrb_pkg and the rtl of the unit; keeps its own model of both rings
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_CYCLES = 1000;

    // one result word as the unit reports it
    typedef struct packed {
        logic                                accepted;
        logic [utrb_pkg::DATA_W-1:0]         read_byte;
        logic                                read_valid;
        logic [utrb_pkg::DATA_W-1:0]         line_byte;
        logic                                line_valid;
        logic                                rx_overflow;
        logic                                echo_lost;
        logic                                request_detected;
        logic [utrb_pkg::RX_COUNT_OUT_W-1:0] rx_count;
        logic [utrb_pkg::TX_COUNT_OUT_W-1:0] tx_count;
    } t_ring_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [7:0]        i_data_byte;
    logic              i_cfg_we;
    logic              i_cfg_data;
    logic              o_done;
    logic              o_accepted;
    logic [7:0]        o_read_byte;
    logic              o_read_valid;
    logic [7:0]        o_line_byte;
    logic              o_line_valid;
    logic              o_rx_overflow;
    logic              o_echo_lost;
    logic              o_request_detected;
    logic [7:0]        o_rx_count;
    logic [5:0]        o_tx_count;

    // model of both rings and the echo register
    logic [utrb_pkg::DATA_W-1:0]   tx_ring [utrb_pkg::TX_DEPTH];
    logic [utrb_pkg::DATA_W-1:0]   rx_ring [utrb_pkg::RX_DEPTH];
    logic [utrb_pkg::TX_PTR_W-1:0] tx_head = '0;
    logic [utrb_pkg::TX_PTR_W-1:0] tx_tail = '0;
    logic [utrb_pkg::RX_PTR_W-1:0] rx_head = '0;
    logic [utrb_pkg::RX_PTR_W-1:0] rx_tail = '0;
    int                            tx_fill = 0;
    int                            rx_fill = 0;
    bit                            echo_on = 1'b0;

    logic [utrb_pkg::DATA_W-1:0] req_codes [5] = '{utrb_pkg::REQ_CODE_A,
                                                   utrb_pkg::REQ_CODE_B,
                                                   utrb_pkg::REQ_CODE_C,
                                                   utrb_pkg::REQ_CODE_D,
                                                   utrb_pkg::REQ_CODE_E};

    t_ring_status outcomes_due [$];

    bit gaps_on      = 1'b1;
    int errors       = 0;
    int words_sent   = 0;
    int words_seen   = 0;
    int rx_drops     = 0;
    int tx_refusals  = 0;
    int echoes_lost  = 0;
    int requests     = 0;
    int idle_cycles  = 0;

    uart_tx_rx_ring_buffers_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_data_byte        (i_data_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_accepted         (o_accepted),
        .o_read_byte        (o_read_byte),
        .o_read_valid       (o_read_valid),
        .o_line_byte        (o_line_byte),
        .o_line_valid       (o_line_valid),
        .o_rx_overflow      (o_rx_overflow),
        .o_echo_lost        (o_echo_lost),
        .o_request_detected (o_request_detected),
        .o_rx_count         (o_rx_count),
        .o_tx_count         (o_tx_count)
    );

    always #5 i_clk = ~i_clk;

    // push into the transmit ring, false when it is full
    function automatic bit tx_take(input logic [utrb_pkg::DATA_W-1:0] b);
        if (tx_fill >= utrb_pkg::TX_DEPTH) begin
            return 1'b0;
        end
        tx_ring[tx_tail] = b;
        tx_tail++;
        tx_fill++;
        return 1'b1;
    endfunction

    // outcome of one word on the model rings
    function automatic t_ring_status ring_outcome(input utrb_pkg::t_cmd cmd,
                                                  input logic [utrb_pkg::DATA_W-1:0] b);
        t_ring_status r;
        logic [utrb_pkg::DATA_W-1:0] popped;
        r = '0;
        case (cmd)
            utrb_pkg::CMD_RX_BYTE: begin
                if (rx_fill + 1 < utrb_pkg::RX_DEPTH) begin
                    rx_ring[rx_tail] = b;
                    rx_tail++;
                    rx_fill++;
                    r.accepted = 1'b1;
                end else begin
                    r.rx_overflow = 1'b1;
                    rx_drops++;
                end
                if (rx_fill == utrb_pkg::REQ_COUNT && b inside {req_codes}) begin
                    r.request_detected = 1'b1;
                    requests++;
                end
            end
            utrb_pkg::CMD_TX_READY: begin
                if (tx_fill != 0) begin
                    r.line_byte  = tx_ring[tx_head];
                    r.line_valid = 1'b1;
                    r.accepted   = 1'b1;
                    tx_head++;
                    tx_fill--;
                end
            end
            utrb_pkg::CMD_HOST_WRITE: begin
                r.accepted = tx_take(b);
                if (!r.accepted) begin
                    tx_refusals++;
                end
            end
            default: begin
                if (rx_fill != 0) begin
                    popped       = rx_ring[rx_head];
                    r.read_byte  = popped;
                    r.read_valid = 1'b1;
                    r.accepted   = 1'b1;
                    rx_head++;
                    rx_fill--;
                    if (echo_on && !tx_take(popped)) begin
                        r.echo_lost = 1'b1;
                        echoes_lost++;
                    end
                end
            end
        endcase
        r.rx_count = rx_fill[utrb_pkg::RX_COUNT_OUT_W-1:0];
        r.tx_count = tx_fill[utrb_pkg::TX_COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // check each result word against the oldest outcome waiting
    always @(posedge i_clk) begin : result_check
        t_ring_status got;
        t_ring_status want;
        if (i_rst_n && o_done) begin
            got = {o_accepted, o_read_byte, o_read_valid, o_line_byte, o_line_valid,
                   o_rx_overflow, o_echo_lost, o_request_detected, o_rx_count, o_tx_count};
            words_seen++;
            if (outcomes_due.size() == 0) begin
                $display("%0t: result word with nothing expected, got %h", $time, got);
                errors++;
            end else begin
                want = outcomes_due.pop_front();
                compare_field("accepted", want.accepted, got.accepted);
                compare_field("read_byte", want.read_byte, got.read_byte);
                compare_field("read_valid", want.read_valid, got.read_valid);
                compare_field("line_byte", want.line_byte, got.line_byte);
                compare_field("line_valid", want.line_valid, got.line_valid);
                compare_field("rx_overflow", want.rx_overflow, got.rx_overflow);
                compare_field("echo_lost", want.echo_lost, got.echo_lost);
                compare_field("request_detected", want.request_detected,
                              got.request_detected);
                compare_field("rx_count", want.rx_count, got.rx_count);
                compare_field("tx_count", want.tx_count, got.tx_count);
            end
        end
    end

    // watchdog on cycles where no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("tb: errors");
                $finish;
            end
        end
    end

    // data byte, biased towards the request codes
    function automatic logic [utrb_pkg::DATA_W-1:0] pick_byte();
        if ($urandom_range(0, 99) < 25) begin
            return req_codes[$urandom_range(0, 4)];
        end
        return utrb_pkg::DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic utrb_pkg::t_cmd pick_cmd(input int w_rx, input int w_tick,
                                                input int w_write);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_rx) begin
            return utrb_pkg::CMD_RX_BYTE;
        end else if (r < w_rx + w_tick) begin
            return utrb_pkg::CMD_TX_READY;
        end else if (r < w_rx + w_tick + w_write) begin
            return utrb_pkg::CMD_HOST_WRITE;
        end
        return utrb_pkg::CMD_HOST_READ;
    endfunction

    // offer one word and wait for the unit to take it; start stays high afterwards
    task automatic send_word(input utrb_pkg::t_cmd cmd, input logic [utrb_pkg::DATA_W-1:0] b);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcomes_due.push_back(ring_outcome(cmd, b));
        words_sent++;
    endtask

    // stop offering and let every expected result come back
    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_echo(input bit v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        echo_on = v;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // idle on empty rings, byte extremes and request codes at the fifth slot
    task automatic test_directed_ops();
        set_echo(1'b0);
        send_word(utrb_pkg::CMD_TX_READY, 8'hFF);
        send_word(utrb_pkg::CMD_HOST_READ, 8'hFF);
        send_word(utrb_pkg::CMD_HOST_WRITE, 8'h00);
        send_word(utrb_pkg::CMD_HOST_WRITE, 8'hFF);
        send_word(utrb_pkg::CMD_TX_READY, 8'h00);
        send_word(utrb_pkg::CMD_TX_READY, 8'hFF);
        send_word(utrb_pkg::CMD_TX_READY, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, 8'hFF);
        send_word(utrb_pkg::CMD_RX_BYTE, 8'h81);
        send_word(utrb_pkg::CMD_RX_BYTE, 8'h33);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_A);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_A);
        send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_B);
        send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_C);
        send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_D);
        send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        send_word(utrb_pkg::CMD_RX_BYTE, utrb_pkg::REQ_CODE_E);
        wait_results();
    endtask

    // host reads copied into the transmit ring and sent out again
    task automatic test_echo_path();
        set_echo(1'b1);
        repeat (3) send_word(utrb_pkg::CMD_HOST_READ, 8'hFF);
        repeat (3) send_word(utrb_pkg::CMD_TX_READY, 8'h00);
        wait_results();
    endtask

    // full receive ring, full transmit ring and echo into a full ring
    task automatic test_ring_limits();
        gaps_on = 1'b0;
        while (rx_fill < utrb_pkg::RX_DEPTH - 1) send_word(utrb_pkg::CMD_RX_BYTE, pick_byte());
        repeat (3) send_word(utrb_pkg::CMD_RX_BYTE, pick_byte());
        gaps_on = 1'b1;
        while (tx_fill < utrb_pkg::TX_DEPTH) send_word(utrb_pkg::CMD_HOST_WRITE, pick_byte());
        repeat (2) send_word(utrb_pkg::CMD_HOST_WRITE, pick_byte());
        repeat (3) send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        repeat (2) send_word(utrb_pkg::CMD_TX_READY, 8'h00);
        repeat (3) send_word(utrb_pkg::CMD_HOST_READ, 8'h00);
        wait_results();
    endtask

    task automatic run_phase(input int n, input bit echo, input bit gaps,
                             input int w_rx, input int w_tick, input int w_write);
        utrb_pkg::t_cmd cmd;
        set_echo(echo);
        gaps_on = gaps;
        repeat (n) begin
            cmd = pick_cmd(w_rx, w_tick, w_write);
            send_word(cmd, pick_byte());
        end
        wait_results();
    endtask

    // random mixes: drain the full rings, then hover near empty for the request codes
    task automatic test_random_traffic();
        run_phase(350, 1'b1, 1'b1, 5, 15, 5);
        run_phase(125, 1'b0, 1'b1, 35, 15, 15);
        run_phase(100, 1'b1, 1'b1, 35, 20, 10);
        run_phase(75, 1'b0, 1'b0, 30, 25, 25);
        run_phase(75, 1'b1, 1'b1, 40, 10, 30);
    endtask

    initial begin
        start       <= 1'b0;
        i_command   <= utrb_pkg::CMD_RX_BYTE;
        i_data_byte <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_echo_path();
        test_ring_limits();
        test_random_traffic();

        wait_results();
        repeat (4) @(posedge i_clk);
        $display("summary: %0d words sent, %0d result words checked", words_sent, words_seen);
        $display("summary: %0d rx drops, %0d refused writes, %0d lost echoes, %0d requests",
                 rx_drops, tx_refusals, echoes_lost, requests);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
